>>> hdl/kmp_pkg.sv
// Shared types and codes for the KMP stream matcher.
package kmp_pkg;

	localparam logic [1:0] MODE_CLEAR   = 2'd0;
	localparam logic [1:0] MODE_APPEND  = 2'd1;
	localparam logic [1:0] MODE_TEXT    = 2'd2;
	localparam logic [1:0] MODE_RESTART = 2'd3;

	localparam int POS_W = 32;

	typedef struct packed {
		logic             match_found;
		logic [POS_W-1:0] match_start;
		logic             status;
	} kmp_result_t;

endpackage

>>> hdl/kmp_store.sv
// Pattern byte memory and failure-link memory, one write and one registered read each.
module kmp_store #(
	parameter int MAX_PATTERN = 32
) (
	input  logic                                                   clk,
	input  logic                                                   pat_we,
	input  logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] pat_waddr,
	input  logic [7:0]                                             pat_wdata,
	input  logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] pat_raddr,
	output logic [7:0]                                             pat_rdata,
	input  logic                                                   fail_we,
	input  logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] fail_waddr,
	input  logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] fail_wdata,
	input  logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] fail_raddr,
	output logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] fail_rdata
);
	localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [7:0]    pat_mem  [MAX_PATTERN];
	logic [IW-1:0] fail_mem [MAX_PATTERN];

	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[pat_waddr] <= pat_wdata;
		end
		pat_rdata <= pat_mem[pat_raddr];
	end

	always_ff @(posedge clk) begin
		if (fail_we) begin
			fail_mem[fail_waddr] <= fail_wdata;
		end
		fail_rdata <= fail_mem[fail_raddr];
	end

endmodule

>>> hdl/kmp_core.sv
// Sequencer and shared byte comparator: builds failure links and walks the text.
module kmp_core #(
	parameter int MAX_PATTERN = 32
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic                                                   in_valid,
	output logic                                                   in_stall,
	input  logic [1:0]                                             mode,
	input  logic [7:0]                                             symbol,
	output logic                                                   res_valid,
	input  logic                                                   res_take,
	output kmp_pkg::kmp_result_t                                   res,
	output logic                                                   pat_we,
	output logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] pat_waddr,
	output logic [7:0]                                             pat_wdata,
	output logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] pat_raddr,
	input  logic [7:0]                                             pat_rdata,
	output logic                                                   fail_we,
	output logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] fail_waddr,
	output logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] fail_wdata,
	output logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] fail_raddr,
	input  logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] fail_rdata
);
	import kmp_pkg::*;

	localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int CW = $clog2(MAX_PATTERN + 1);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_READ    = 3'd1;
	localparam logic [2:0] ST_CMP     = 3'd2;
	localparam logic [2:0] ST_TAIL_RD = 3'd3;
	localparam logic [2:0] ST_TAIL    = 3'd4;
	localparam logic [2:0] ST_DONE    = 3'd5;

	logic [2:0]       state_q;
	logic [CW-1:0]    count_q;
	logic [IW-1:0]    build_q;
	logic [IW-1:0]    matched_q;
	logic [POS_W-1:0] pos_q;
	logic [1:0]       mode_q;
	logic [7:0]       sym_q;
	logic [IW-1:0]    len_q;
	kmp_result_t      res_q;

	logic          accept;
	logic          full;
	logic          eq;
	logic          fall_back;
	logic [CW-1:0] next_len;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE);
	assign full      = (count_q >= CW'(MAX_PATTERN));
	assign eq        = (pat_rdata == sym_q);
	assign fall_back = (len_q != '0) && !eq;
	assign next_len  = CW'(len_q) + CW'(eq);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	assign pat_we    = accept && (mode == MODE_APPEND) && !full;
	assign pat_waddr = IW'(count_q);
	assign pat_wdata = symbol;
	assign pat_raddr = len_q;

	always_comb begin
		if (state_q == ST_TAIL_RD) begin
			fail_raddr = IW'(count_q - CW'(1));
		end else if (len_q == '0) begin
			fail_raddr = '0;
		end else begin
			fail_raddr = len_q - IW'(1);
		end
	end

	// first pattern byte links to zero at once; later ones when the fallback walk ends
	always_comb begin
		fail_we    = 1'b0;
		fail_waddr = IW'(count_q);
		fail_wdata = IW'(next_len);
		if (pat_we && (count_q == '0)) begin
			fail_we    = 1'b1;
			fail_wdata = '0;
		end else if ((state_q == ST_CMP) && !fall_back && (mode_q == MODE_APPEND)) begin
			fail_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			build_q   <= '0;
			matched_q <= '0;
			pos_q     <= '0;
			mode_q    <= MODE_CLEAR;
			sym_q     <= '0;
			len_q     <= '0;
			res_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q <= mode;
						sym_q  <= symbol;
						res_q  <= '0;
						case (mode)
							MODE_CLEAR: begin
								count_q   <= '0;
								build_q   <= '0;
								matched_q <= '0;
								pos_q     <= '0;
								state_q   <= ST_DONE;
							end
							MODE_APPEND: begin
								if (full) begin
									res_q.status <= 1'b1;
									state_q      <= ST_DONE;
								end else if (count_q == '0) begin
									build_q <= '0;
									count_q <= CW'(1);
									state_q <= ST_DONE;
								end else begin
									len_q   <= build_q;
									state_q <= ST_READ;
								end
							end
							MODE_TEXT: begin
								if (count_q == '0) begin
									matched_q <= '0;
									pos_q     <= pos_q + POS_W'(1);
									state_q   <= ST_DONE;
								end else begin
									len_q   <= (CW'(matched_q) >= count_q) ? '0 : matched_q;
									state_q <= ST_READ;
								end
							end
							default: begin
								matched_q <= '0;
								pos_q     <= '0;
								state_q   <= ST_DONE;
							end
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (fall_back) begin
						len_q   <= fail_rdata;
						state_q <= ST_READ;
					end else if (mode_q == MODE_APPEND) begin
						build_q <= IW'(next_len);
						count_q <= count_q + CW'(1);
						state_q <= ST_DONE;
					end else if (next_len == count_q) begin
						res_q.match_found <= 1'b1;
						res_q.match_start <= pos_q - POS_W'(count_q) + POS_W'(1);
						pos_q             <= pos_q + POS_W'(1);
						state_q           <= ST_TAIL_RD;
					end else begin
						matched_q <= IW'(next_len);
						pos_q     <= pos_q + POS_W'(1);
						state_q   <= ST_DONE;
					end
				end
				ST_TAIL_RD: begin
					state_q <= ST_TAIL;
				end
				ST_TAIL: begin
					// after a full match, resume from the last link
					matched_q <= fail_rdata;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/kmp_stream_matcher_top.sv
// Top level of the KMP stream matcher: core, pattern memories and output register.
// Usage:
//   Input channel in_valid/in_stall carries one request of mode and symbol.
//   mode 0 clears pattern and text state, 1 appends a pattern byte, 2 feeds a
//   text byte, 3 restarts the text position. Every request yields one result.
//   Output channel out_valid/out_stall carries match_found, match_start and status.
// Timing:
//   After acceptance a request walks the failure links, each byte compare being a
//   memory read then a compare, and a text byte that completes a match then fetches
//   the last failure link; the result then goes to the output register. Clear,
//   restart, a dropped pattern byte, the first pattern byte and a text byte with
//   no pattern loaded skip the walk.
//   The next request is accepted the cycle after the result leaves the core, so
//   the core works on one request at a time.
//   Over a long text stream the walk averages at most two compares per byte.
//   in_stall is high while the core works on a request, until the result is handed over.
// Reset clears the pattern length, match state and text position; the
// memories are not cleared and are only read where written.
// A stalled result stays in the output register while the next request is
// worked on; that one waits in the core until the register frees.
module kmp_stream_matcher_top #(
	parameter int MAX_PATTERN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  symbol,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        match_found,
	output logic [31:0] match_start,
	output logic        status
);
	import kmp_pkg::*;

	localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic          res_valid;
	logic          res_take;
	kmp_result_t   res;
	logic          pat_we;
	logic [IW-1:0] pat_waddr;
	logic [7:0]    pat_wdata;
	logic [IW-1:0] pat_raddr;
	logic [7:0]    pat_rdata;
	logic          fail_we;
	logic [IW-1:0] fail_waddr;
	logic [IW-1:0] fail_wdata;
	logic [IW-1:0] fail_raddr;
	logic [IW-1:0] fail_rdata;

	logic        out_valid_q;
	kmp_result_t out_q;

	kmp_core #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.symbol    (symbol),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.pat_we    (pat_we),
		.pat_waddr (pat_waddr),
		.pat_wdata (pat_wdata),
		.pat_raddr (pat_raddr),
		.pat_rdata (pat_rdata),
		.fail_we   (fail_we),
		.fail_waddr(fail_waddr),
		.fail_wdata(fail_wdata),
		.fail_raddr(fail_raddr),
		.fail_rdata(fail_rdata)
	);

	kmp_store #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_store (
		.clk       (clk),
		.pat_we    (pat_we),
		.pat_waddr (pat_waddr),
		.pat_wdata (pat_wdata),
		.pat_raddr (pat_raddr),
		.pat_rdata (pat_rdata),
		.fail_we   (fail_we),
		.fail_waddr(fail_waddr),
		.fail_wdata(fail_wdata),
		.fail_raddr(fail_raddr),
		.fail_rdata(fail_rdata)
	);

	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign match_found = out_q.match_found;
	assign match_start = out_q.match_start;
	assign status      = out_q.status;

endmodule
